// ===== rtl/psg_pkg.sv =====
// ----------------------------------------------------------------------------
// psg_pkg
// Shared types and constants for the programmable sound generator core.
// ----------------------------------------------------------------------------
`default_nettype none

package psg_pkg;

	localparam int NUM_CH    = 3;
	localparam int NUM_REGS  = 16;
	localparam int TONE_W    = 12;
	localparam int NOISE_W   = 5;
	localparam int LFSR_W    = 17;
	localparam int ENV_CNT_W = 17;
	localparam int ENV_POS_W = 5;
	localparam int LEVEL_W   = 5;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 1;

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_YM_FAMILY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDE_ENV  = 1'd1;

	localparam logic [3:0] REG_NOISE_PER = 4'd6;
	localparam logic [3:0] REG_MIXER     = 4'd7;
	localparam logic [3:0] REG_AMP_A     = 4'd8;
	localparam logic [3:0] REG_ENV_LO    = 4'd11;
	localparam logic [3:0] REG_ENV_HI    = 4'd12;
	localparam logic [3:0] REG_ENV_SHAPE = 4'd13;

	localparam logic [ENV_POS_W-1:0] MASK_AY = 5'h0f;
	localparam logic [ENV_POS_W-1:0] MASK_YM = 5'h1f;

	typedef struct packed {
		logic [1:0] req_type;
		logic       port_addr;
		logic [7:0] data_byte;
	} psg_req_t;

	typedef struct packed {
		logic [7:0]         read_data;
		logic [LEVEL_W-1:0] level_a;
		logic [LEVEL_W-1:0] level_b;
		logic [LEVEL_W-1:0] level_c;
		logic               env_sel_a;
		logic               env_sel_b;
		logic               env_sel_c;
	} psg_res_t;

	// read-back mask per register in the YM family
	function automatic logic [7:0] read_mask(input logic [3:0] idx);
		logic [7:0] m;
		case (idx)
			4'd0:    m = 8'hff;
			4'd1:    m = 8'h0f;
			4'd2:    m = 8'hff;
			4'd3:    m = 8'h0f;
			4'd4:    m = 8'hff;
			4'd5:    m = 8'h0f;
			4'd6:    m = 8'h1f;
			4'd7:    m = 8'hff;
			4'd8:    m = 8'h1f;
			4'd9:    m = 8'h1f;
			4'd10:   m = 8'h1f;
			4'd11:   m = 8'hff;
			4'd12:   m = 8'hff;
			4'd13:   m = 8'h0f;
			default: m = 8'hff;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/programmable_sound_generator_core.sv =====
// ----------------------------------------------------------------------------
// programmable_sound_generator_core
// Three-channel tone/noise/envelope sound generator with a 16-entry register
// file, driven by bus write, bus read and sample tick items.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item passes through the input register, then the result
// register. Throughput: one item per cycle while the result is not stalled; the tick
// update is a single pass through the counters, LFSR and envelope. Reset (async,
// active low) clears the register file, the generators and the pipeline valids.
// ----------------------------------------------------------------------------
`default_nettype none

module programmable_sound_generator_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             req_valid,
	output logic                                  req_stall,
	input  wire psg_pkg::psg_req_t                req_item,
	output logic                                  res_valid,
	input  wire logic                             res_stall,
	output psg_pkg::psg_res_t                     res_item,
	input  wire logic                             cfg_we,
	input  wire logic [psg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [psg_pkg::CFG_DAT_W-1:0]    cfg_data
);

	localparam int NCH = psg_pkg::NUM_CH;
	localparam int PW  = psg_pkg::ENV_POS_W;

	logic ym_q;
	logic wide_q;

	logic              s1_valid;
	psg_pkg::psg_req_t s1_item;
	logic              fire;

	logic [7:0]                     rf_q [psg_pkg::NUM_REGS];
	logic [3:0]                     sel_q;
	logic [psg_pkg::TONE_W-1:0]     tone_cnt_q [NCH];
	logic [NCH-1:0]                 tone_sq_q;
	logic [psg_pkg::NOISE_W-1:0]    noise_cnt_q;
	logic                           presc_q;
	logic [psg_pkg::LFSR_W-1:0]     lfsr_q;
	logic [psg_pkg::ENV_CNT_W-1:0]  env_cnt_q;
	logic [PW-1:0]                  env_pos_q;
	logic [PW-1:0]                  attack_q;
	logic                           hold_q;
	logic                           alt_q;
	logic                           holding_q;

	logic [psg_pkg::TONE_W-1:0]     tone_cnt_d [NCH];
	logic [NCH-1:0]                 tone_sq_d;
	logic [psg_pkg::NOISE_W-1:0]    noise_cnt_d;
	logic                           presc_d;
	logic [psg_pkg::LFSR_W-1:0]     lfsr_d;
	logic [psg_pkg::ENV_CNT_W-1:0]  env_cnt_d;
	logic [PW-1:0]                  env_pos_d;
	logic [PW-1:0]                  attack_d;
	logic                           holding_d;

	logic [PW-1:0]                  mask;
	logic [PW-1:0]                  env_level;
	logic [psg_pkg::LEVEL_W-1:0]    lvl [NCH];
	logic [NCH-1:0]                 esel;
	psg_pkg::psg_res_t              res_d;

	// shape register side effects
	logic [7:0]    shape;
	logic [PW-1:0] shape_attack;
	logic          shape_hold;
	logic          shape_alt;

	logic is_tick;
	logic is_store;

	assign fire      = s1_valid && (!res_valid || !res_stall);
	assign req_stall = s1_valid && res_valid && res_stall;
	assign mask      = ym_q ? psg_pkg::MASK_YM : psg_pkg::MASK_AY;
	assign is_tick   = fire && (s1_item.req_type == psg_pkg::REQ_TICK);
	assign is_store  = fire && (s1_item.req_type == psg_pkg::REQ_WRITE) && s1_item.port_addr;

	assign shape        = s1_item.data_byte;
	assign shape_attack = shape[2] ? mask : '0;
	assign shape_hold   = shape[3] ? shape[0] : 1'b1;
	assign shape_alt    = shape[3] ? shape[1] : shape[2];

	// tick update
	always_comb begin
		logic [psg_pkg::TONE_W-1:0]    per;
		logic [psg_pkg::TONE_W-1:0]    tinc;
		logic [psg_pkg::NOISE_W-1:0]   ninc;
		logic [psg_pkg::ENV_CNT_W-1:0] lim;
		logic [psg_pkg::ENV_CNT_W-1:0] einc;
		logic [15:0]                   eper;

		for (int ch = 0; ch < NCH; ch++) begin
			per  = {rf_q[2*ch+1][3:0], rf_q[2*ch]};
			tinc = tone_cnt_q[ch] + 1'b1;
			if (tinc >= per) begin
				tone_cnt_d[ch] = '0;
				tone_sq_d[ch]  = ~tone_sq_q[ch];
			end else begin
				tone_cnt_d[ch] = tinc;
				tone_sq_d[ch]  = tone_sq_q[ch];
			end
		end

		ninc    = noise_cnt_q + 1'b1;
		presc_d = presc_q;
		lfsr_d  = lfsr_q;
		if (ninc >= rf_q[psg_pkg::REG_NOISE_PER][4:0]) begin
			noise_cnt_d = '0;
			presc_d     = ~presc_q;
			if (!presc_q) begin
				lfsr_d = {lfsr_q[0] ^ lfsr_q[3], lfsr_q[psg_pkg::LFSR_W-1:1]};
			end
		end else begin
			noise_cnt_d = ninc;
		end

		eper      = {rf_q[psg_pkg::REG_ENV_HI], rf_q[psg_pkg::REG_ENV_LO]};
		lim       = ym_q ? {1'b0, eper} : {eper, 1'b0};
		einc      = env_cnt_q + 1'b1;
		env_cnt_d = env_cnt_q;
		env_pos_d = env_pos_q;
		attack_d  = attack_q;
		holding_d = holding_q;
		if (!holding_q) begin
			env_cnt_d = einc;
			if (einc >= lim) begin
				env_cnt_d = '0;
				if (env_pos_q != '0) begin
					env_pos_d = env_pos_q - 1'b1;
				end else begin
					if (alt_q) begin
						attack_d = attack_q ^ mask;
					end
					if (hold_q) begin
						holding_d = 1'b1;
					end else begin
						env_pos_d = mask;
					end
				end
			end
		end
	end

	assign env_level = env_pos_d ^ attack_d;

	// channel gating
	always_comb begin
		logic [7:0] amp;
		logic [1:0] ef;
		logic       gate;
		logic [PW-1:0] e;

		for (int ch = 0; ch < NCH; ch++) begin
			amp  = rf_q[psg_pkg::REG_AMP_A + 4'(ch)];
			ef   = amp[5:4] & (wide_q ? 2'b11 : 2'b01);
			gate = (tone_sq_d[ch] | rf_q[psg_pkg::REG_MIXER][ch])
				& (lfsr_d[0] | rf_q[psg_pkg::REG_MIXER][3+ch]);
			e    = wide_q ? (env_level >> (2'd3 - ef)) : env_level;
			if (ef != 2'd0) begin
				lvl[ch] = gate ? e : '0;
			end else begin
				lvl[ch] = gate ? {1'b0, amp[3:0]} : '0;
			end
			esel[ch] = (ef != 2'd0);
		end
	end

	always_comb begin
		res_d = '0;
		case (s1_item.req_type)
			psg_pkg::REQ_READ: begin
				res_d.read_data = rf_q[sel_q] & (ym_q ? psg_pkg::read_mask(sel_q) : 8'hff);
			end
			psg_pkg::REQ_TICK: begin
				res_d.level_a   = lvl[0];
				res_d.level_b   = lvl[1];
				res_d.level_c   = lvl[2];
				res_d.env_sel_a = esel[0];
				res_d.env_sel_b = esel[1];
				res_d.env_sel_c = esel[2];
			end
			default: begin
				res_d = '0;
			end
		endcase
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ym_q   <= 1'b0;
			wide_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				psg_pkg::CFG_YM_FAMILY: ym_q   <= cfg_data[0];
				psg_pkg::CFG_WIDE_ENV:  wide_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (!req_stall) begin
			s1_valid <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			s1_item <= req_item;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (fire) begin
			res_valid <= 1'b1;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_item <= res_d;
		end
	end

	// register file and generator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < psg_pkg::NUM_REGS; i++) begin
				rf_q[i] <= '0;
			end
			sel_q       <= '0;
			for (int ch = 0; ch < NCH; ch++) begin
				tone_cnt_q[ch] <= '0;
			end
			tone_sq_q   <= '0;
			noise_cnt_q <= '0;
			presc_q     <= 1'b0;
			lfsr_q      <= psg_pkg::LFSR_W'(1);
			env_cnt_q   <= '0;
			env_pos_q   <= psg_pkg::MASK_AY;
			attack_q    <= '0;
			hold_q      <= 1'b1;
			alt_q       <= 1'b0;
			holding_q   <= 1'b0;
		end else begin
			if (fire && (s1_item.req_type == psg_pkg::REQ_WRITE) && !s1_item.port_addr) begin
				sel_q <= s1_item.data_byte[3:0];
			end
			if (is_store) begin
				rf_q[sel_q] <= s1_item.data_byte;
				if (sel_q == psg_pkg::REG_ENV_SHAPE) begin
					attack_q  <= shape_attack;
					hold_q    <= shape_hold;
					alt_q     <= shape_alt;
					env_pos_q <= mask;
					holding_q <= 1'b0;
				end
			end
			if (is_tick) begin
				for (int ch = 0; ch < NCH; ch++) begin
					tone_cnt_q[ch] <= tone_cnt_d[ch];
				end
				tone_sq_q   <= tone_sq_d;
				noise_cnt_q <= noise_cnt_d;
				presc_q     <= presc_d;
				lfsr_q      <= lfsr_d;
				env_cnt_q   <= env_cnt_d;
				env_pos_q   <= env_pos_d;
				attack_q    <= attack_d;
				holding_q   <= holding_d;
			end
		end
	end

endmodule

`default_nettype wire
